// ===== hw/rtl/isc_pkg.sv =====
// Shared types and codes for the integer stack calculator.
// Used by the front decoder, the execute unit and the top level.
package isc_pkg;

   typedef enum logic [2:0] {
      KIND_PUSH  = 3'd0,
      KIND_POP   = 3'd1,
      KIND_PEEKT = 3'd2,
      KIND_PEEKB = 3'd3,
      KIND_ADD   = 3'd4,
      KIND_SUB   = 3'd5,
      KIND_MUL   = 3'd6,
      KIND_DIV   = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK    = 3'd0,
      ST_EMPTY = 3'd1,
      ST_RANGE = 3'd2,
      ST_FEW   = 3'd3,
      ST_DIV0  = 3'd4,
      ST_FULL  = 3'd5
   } status_type;

   typedef enum logic [2:0] {
      EX_IDLE,
      EX_READ_T,
      EX_READ_S,
      EX_MUL,
      EX_DIV,
      EX_WRITE,
      EX_RESP
   } ex_state_type;

   localparam int unsigned KIND_W   = 3;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned INDEX_W  = 10;

endpackage

// ===== hw/rtl/isc_queue.sv =====
// Two-entry queue between the front decoder and the execute unit.
// Depends on nothing but its parameter.
module isc_queue #(
   parameter int unsigned W = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_stall,
   input  logic [W-1:0] in_data,
   output logic         out_valid,
   input  logic         out_stall,
   output logic [W-1:0] out_data
);
   logic [W-1:0] mem_ff [2];
   logic         wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && !in_stall;
   assign pop  = out_valid && !out_stall;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         mem_ff[wp_ff] <= in_data;
      end
   end
endmodule

// ===== hw/rtl/isc_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle, floor rounding.
// Depends on nothing but its parameter.
module isc_divider #(
   parameter int unsigned WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);
   localparam int unsigned CW = $clog2(WIDTH + 1);
   logic             busy_ff, busy_in, done_ff, done_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [WIDTH-1:0] q_ff, q_in, d_ff, d_in;
   logic [WIDTH:0]   r_ff, r_in, trial;
   logic             neg_ff, neg_in;
   logic [WIDTH-1:0] ma, mb, qf;

   always_comb begin
      ma = dividend[WIDTH-1] ? (~dividend + 1'b1) : dividend;
      mb = divisor[WIDTH-1] ? (~divisor + 1'b1) : divisor;
      trial   = {r_ff[WIDTH-1:0], q_ff[WIDTH-1]} - {1'b0, d_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CW'(WIDTH);
         q_in    = ma;
         r_in    = '0;
         d_in    = mb;
         neg_in  = dividend[WIDTH-1] ^ divisor[WIDTH-1];
      end else if (busy_ff) begin
         if (trial[WIDTH]) begin
            r_in = {r_ff[WIDTH-1:0], q_ff[WIDTH-1]};
            q_in = {q_ff[WIDTH-2:0], 1'b0};
         end else begin
            r_in = trial;
            q_in = {q_ff[WIDTH-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
      qf = q_ff + {{(WIDTH-1){1'b0}}, (r_ff != '0)};
      quotient = neg_ff ? (~qf + 1'b1) : q_ff;
   end

   assign done = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      d_ff   <= d_in;
      neg_ff <= neg_in;
   end
endmodule

// ===== hw/rtl/isc_front.sv =====
// Front end: accept request beats and pack them for the queue.
// Depends on isc_pkg and isc_queue.
module isc_front #(
   parameter int unsigned WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [isc_pkg::KIND_W-1:0]  req_kind,
   input  logic [WIDTH-1:0]            req_push_value,
   input  logic [isc_pkg::INDEX_W-1:0] req_peek_index,
   output logic                        q_valid,
   input  logic                        q_stall,
   output logic [isc_pkg::KIND_W+WIDTH+isc_pkg::INDEX_W-1:0] q_data
);
   import isc_pkg::*;
   localparam int unsigned PW = KIND_W + WIDTH + INDEX_W;

   isc_queue #(.W(PW)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_stall (req_stall),
      .in_data  ({req_kind, req_push_value, req_peek_index}),
      .out_valid(q_valid),
      .out_stall(q_stall),
      .out_data (q_data)
   );
endmodule

// ===== hw/rtl/isc_exec.sv =====
// Back end: stack memory, fill count and arithmetic sequencer.
// Depends on isc_pkg and isc_divider.
module isc_exec #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   output logic                        q_stall,
   input  logic [isc_pkg::KIND_W+WIDTH+isc_pkg::INDEX_W-1:0] q_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [31:0]                 rsp_result_value,
   output logic [isc_pkg::STATUS_W-1:0] rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]  rsp_depth
);
   import isc_pkg::*;
   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   ex_state_type     state_ff, state_in;
   logic [CW-1:0]    fill_ff, fill_in;
   kind_type         kind_ff;
   logic [WIDTH-1:0] pv_ff, t_ff, s_ff, res_ff, res_in;
   logic [INDEX_W-1:0] idx_ff;
   logic [2:0]       st_ff, st_in;
   logic             rv_ff, rv_in;
   logic [31:0]      orv_ff;
   logic [STATUS_W-1:0] ost_ff;
   logic [CW-1:0]    odp_ff;
   logic             take, wr_en, div_start, div_done, t_in_en, s_in_en;
   logic [AW-1:0]    rd_addr, wr_addr;
   logic [WIDTH-1:0] wr_data, quo;
   logic [CW-1:0]    idx_w, top_pos;
   logic [KIND_W-1:0] qk;

   assign qk      = q_data[KIND_W+WIDTH+INDEX_W-1 -: KIND_W];
   assign take    = q_valid && !q_stall;
   assign q_stall = (state_ff != EX_IDLE) || rv_ff;
   assign idx_w   = CW'(idx_ff);

   isc_divider #(.WIDTH(WIDTH)) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(rd_ff),
      .divisor (t_ff),
      .done    (div_done),
      .quotient(quo)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         EX_IDLE:   if (take) state_in = EX_READ_T;
         EX_READ_T: begin
            unique case (kind_ff)
               KIND_PUSH:  state_in = (fill_ff >= CW'(DEPTH)) ? EX_RESP : EX_WRITE;
               KIND_POP:   state_in = EX_RESP;
               KIND_PEEKT, KIND_PEEKB: state_in = EX_RESP;
               default:    state_in = (fill_ff < CW'(2)) ? EX_RESP : EX_READ_S;
            endcase
         end
         EX_READ_S: begin
            if (kind_ff == KIND_DIV) state_in = (t_ff == '0) ? EX_RESP : EX_DIV;
            else state_in = EX_MUL;
         end
         EX_MUL:    state_in = EX_WRITE;
         EX_DIV:    if (div_done) state_in = EX_WRITE;
         EX_WRITE:  state_in = EX_RESP;
         EX_RESP:   state_in = EX_IDLE;
         default:   state_in = EX_IDLE;
      endcase
   end

   always_comb begin
      top_pos   = fill_ff - 1'b1;
      rd_addr   = AW'(top_pos);
      wr_en     = 1'b0;
      wr_addr   = AW'(fill_ff);
      wr_data   = pv_ff;
      div_start = 1'b0;
      t_in_en   = 1'b0;
      s_in_en   = 1'b0;
      fill_in   = fill_ff;
      res_in    = res_ff;
      st_in     = st_ff;
      rv_in     = rv_ff && rsp_stall;
      unique case (state_ff)
         EX_IDLE: begin
            res_in = '0;
            st_in = ST_OK;
         end
         EX_READ_T: begin
            unique case (kind_ff)
               KIND_PUSH: if (fill_ff >= CW'(DEPTH)) st_in = ST_FULL;
               KIND_POP: begin
                  if (fill_ff == '0) st_in = ST_EMPTY;
                  else begin
                     res_in  = rd_ff;
                     fill_in = top_pos;
                  end
               end
               KIND_PEEKT, KIND_PEEKB: begin
                  if (idx_w >= fill_ff) st_in = ST_RANGE;
                  else res_in = rd_ff;
               end
               default: begin
                  if (fill_ff < CW'(2)) st_in = ST_FEW;
                  t_in_en = 1'b1;
               end
            endcase
         end
         EX_READ_S: begin
            s_in_en = 1'b1;
            if (kind_ff == KIND_DIV) begin
               if (t_ff == '0) begin
                  st_in   = ST_DIV0;
                  fill_in = fill_ff - CW'(2);
               end else begin
                  div_start = 1'b1;
               end
            end
         end
         EX_MUL: begin
            unique case (kind_ff)
               KIND_ADD: res_in = s_ff + t_ff;
               KIND_SUB: res_in = s_ff - t_ff;
               default:  res_in = WIDTH'(s_ff * t_ff);
            endcase
         end
         EX_DIV: if (div_done) res_in = quo;
         EX_WRITE: begin
            wr_en = 1'b1;
            if (kind_ff == KIND_PUSH) begin
               fill_in = fill_ff + 1'b1;
            end else begin
               wr_addr = AW'(fill_ff - CW'(2));
               wr_data = res_ff;
               fill_in = top_pos;
            end
         end
         EX_RESP: rv_in = 1'b1;
         default: ;
      endcase
   end

   // stack read address: picked in the idle state from the incoming beat
   logic [AW-1:0] raddr_q;
   logic [INDEX_W-1:0] qidx;
   assign qidx = q_data[INDEX_W-1:0];
   always_comb begin
      unique case (kind_type'(qk))
         KIND_PEEKT: raddr_q = AW'(fill_ff - CW'(1) - CW'(qidx));
         KIND_PEEKB: raddr_q = AW'(qidx);
         default:    raddr_q = rd_addr;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (state_ff == EX_IDLE) rd_ff <= mem[raddr_q];
      else if (state_ff == EX_READ_T) rd_ff <= mem[AW'(fill_ff - CW'(2))];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EX_IDLE;
         fill_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         rv_ff    <= rv_in;
      end
      if (take) begin
         kind_ff <= kind_type'(qk);
         pv_ff   <= q_data[WIDTH+INDEX_W-1 -: WIDTH];
         idx_ff  <= qidx;
      end
      if (t_in_en) t_ff <= rd_ff;
      if (s_in_en) s_ff <= rd_ff;
      res_ff <= res_in;
      st_ff  <= st_in;
      if (state_ff == EX_RESP) begin
         orv_ff <= 32'(res_ff);
         ost_ff <= st_ff;
         odp_ff <= fill_ff;
      end
   end

   assign rsp_valid        = rv_ff;
   assign rsp_result_value = orv_ff;
   assign rsp_status       = ost_ff;
   assign rsp_depth        = odp_ff;
endmodule

// ===== hw/rtl/integer_stack_calculator_core.sv =====
// Integer stack calculator: RPN stack of signed words with arithmetic.
// Each beat runs through the stack memory read/write sequence, and divide
// also through the one-bit-per-cycle divider; the exec unit takes a new beat
// only once the last response has been taken, while the two-entry front queue
// keeps accepting beats until it is full.
// Reset is synchronous: the stack is empty, memory contents are left as is.
// Depends on isc_pkg, isc_front and isc_exec.
module integer_stack_calculator_core #(
   parameter int unsigned DEPTH = 1024,
   parameter int unsigned WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [isc_pkg::KIND_W-1:0]   req_kind,
   input  logic [WIDTH-1:0]             req_push_value,
   input  logic [isc_pkg::INDEX_W-1:0]  req_peek_index,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [31:0]                  rsp_result_value,
   output logic [isc_pkg::STATUS_W-1:0] rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]   rsp_depth
);
   import isc_pkg::*;
   localparam int unsigned PW = KIND_W + WIDTH + INDEX_W;

   logic          q_valid, q_stall;
   logic [PW-1:0] q_data;

   isc_front #(.WIDTH(WIDTH)) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_kind      (req_kind),
      .req_push_value(req_push_value),
      .req_peek_index(req_peek_index),
      .q_valid       (q_valid),
      .q_stall       (q_stall),
      .q_data        (q_data)
   );

   isc_exec #(.DEPTH(DEPTH), .WIDTH(WIDTH)) u_exec (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_stall         (q_stall),
      .q_data          (q_data),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_result_value(rsp_result_value),
      .rsp_status      (rsp_status),
      .rsp_depth       (rsp_depth)
   );
endmodule

// ===== sim/tb.sv =====
// Self-checking bench for integer_stack_calculator_core: a table of directed beats, a fill
// to overflow with a drain, then random traffic, each beat checked against a local stack model.
// Depends on isc_pkg and the core RTL.
module tb;
   import isc_pkg::*;

   localparam int unsigned DEPTH = 1024;
   localparam int unsigned WIDTH = 32;
   localparam int unsigned DW = $clog2(DEPTH + 1);
   localparam int WATCH_LIMIT = 20000;

   typedef struct packed {
      logic [WIDTH-1:0] value;
      status_type       status;
      logic [DW-1:0]    depth;
   } answer_type;

   typedef struct {
      kind_type         kind;
      logic [WIDTH-1:0] value;
      logic [9:0]       index;
      bit               typed;
      answer_type       answer;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [KIND_W-1:0] req_kind = '0;
   logic [WIDTH-1:0] req_push_value = '0;
   logic [INDEX_W-1:0] req_peek_index = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [31:0] rsp_result_value;
   logic [STATUS_W-1:0] rsp_status;
   logic [DW-1:0] rsp_depth;

   logic [WIDTH-1:0] calc_stack [DEPTH];
   int unsigned calc_fill = 0;
   answer_type pending_answers [$];
   int mismatches = 0;
   int idle_cycles = 0;
   bit quiet = 1'b0;
   bit timed_out = 1'b0;
   row_type rows [$];

   integer_stack_calculator_core #(.DEPTH(DEPTH), .WIDTH(WIDTH)) dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [WIDTH-1:0] floor_quot(logic [WIDTH-1:0] s, logic [WIDTH-1:0] t);
      logic [WIDTH-1:0] ms, mt, q, r;
      ms = s[WIDTH-1] ? -s : s;
      mt = t[WIDTH-1] ? -t : t;
      q = ms / mt;
      r = ms % mt;
      if (s[WIDTH-1] != t[WIDTH-1])
         return -(q + (r != 0));
      return q;
   endfunction

   function automatic answer_type calc_apply(kind_type k, logic [WIDTH-1:0] v,
                                             logic [9:0] idx);
      answer_type a;
      logic [WIDTH-1:0] s, t;
      a.value = '0;
      a.status = ST_OK;
      case (k)
         KIND_PUSH: begin
            if (calc_fill >= DEPTH) a.status = ST_FULL;
            else calc_stack[calc_fill++] = v;
         end
         KIND_POP: begin
            if (calc_fill == 0) a.status = ST_EMPTY;
            else a.value = calc_stack[--calc_fill];
         end
         KIND_PEEKT, KIND_PEEKB: begin
            if (idx >= calc_fill) a.status = ST_RANGE;
            else a.value = calc_stack[k == KIND_PEEKT ? calc_fill - 1 - idx : idx];
         end
         default: begin
            if (calc_fill < 2) a.status = ST_FEW;
            else begin
               t = calc_stack[calc_fill - 1];
               s = calc_stack[calc_fill - 2];
               if (k == KIND_DIV && t == 0) begin
                  calc_fill -= 2;
                  a.status = ST_DIV0;
               end else begin
                  case (k)
                     KIND_ADD: a.value = s + t;
                     KIND_SUB: a.value = s - t;
                     KIND_MUL: a.value = s * t;
                     default:  a.value = floor_quot(s, t);
                  endcase
                  calc_fill -= 1;
                  calc_stack[calc_fill - 1] = a.value;
               end
            end
         end
      endcase
      a.depth = DW'(calc_fill);
      return a;
   endfunction

   always @(posedge clock) begin
      if (!reset && ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))) idle_cycles <= 0;
      else if (!reset) idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT && !timed_out) begin
         timed_out = 1'b1;
         $display("CHECKS FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      answer_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat: %h", rsp_result_value);
         end else begin
            e = pending_answers.pop_front();
            if (rsp_result_value !== e.value || rsp_status !== e.status
                || rsp_depth !== e.depth) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp %h/%0d/%0d got %h/%0d/%0d", e.value, e.status,
                           e.depth, rsp_result_value, rsp_status, rsp_depth);
            end
         end
      end
   end

   initial begin : rsp_side
      int n;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (quiet) rsp_stall <= 1'b0;
         else if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 11);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_beat(kind_type k, logic [WIDTH-1:0] v, logic [9:0] idx,
                            bit typed, answer_type typed_answer);
      answer_type a;
      int n;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         n = $urandom_range(1, 11);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= k;
      req_push_value <= v;
      req_peek_index <= idx;
      a = calc_apply(k, v, idx);
      if (typed && a !== typed_answer) begin
         mismatches++;
         if (mismatches <= 10) $display("table row disagrees with model, kind %0d", k);
      end
      pending_answers.push_back(a);
      do @(posedge clock); while (req_stall);
   endtask

   task automatic add_row(kind_type k, logic [WIDTH-1:0] v, logic [9:0] idx, bit typed,
                          logic [WIDTH-1:0] ev, status_type es, logic [DW-1:0] ed);
      row_type r;
      r.kind = k; r.value = v; r.index = idx; r.typed = typed;
      r.answer = '{ev, es, ed};
      rows.push_back(r);
   endtask

   function automatic logic [WIDTH-1:0] rand_value();
      case ($urandom_range(0, 5))
         0: return {1'b1, {(WIDTH-1){1'b0}}};
         1: return {1'b0, {(WIDTH-1){1'b1}}};
         2: return $urandom_range(0, 7) - 3;
         3: return {$urandom} >> $urandom_range(0, 28);
         default: return $urandom;
      endcase
   endfunction

   initial begin : req_side
      kind_type k;
      int n;
      logic [WIDTH-1:0] minv, maxv;
      minv = {1'b1, {(WIDTH-1){1'b0}}};
      maxv = {1'b0, {(WIDTH-1){1'b1}}};
      add_row(KIND_POP,   0, 0,    1, 0, ST_EMPTY, 0);
      add_row(KIND_PEEKT, 0, 0,    1, 0, ST_RANGE, 0);
      add_row(KIND_ADD,   0, 0,    1, 0, ST_FEW,   0);
      add_row(KIND_PUSH,  maxv, 0, 1, 0, ST_OK,    1);
      add_row(KIND_MUL,   0, 0,    1, 0, ST_FEW,   1);
      add_row(KIND_PUSH,  1, 0,    1, 0, ST_OK,    2);
      add_row(KIND_ADD,   0, 0,    1, minv, ST_OK, 1);
      add_row(KIND_PUSH,  -1, 0,   1, 0, ST_OK,    2);
      add_row(KIND_DIV,   0, 0,    1, minv, ST_OK, 1);
      add_row(KIND_PUSH,  0, 0,    1, 0, ST_OK,    2);
      add_row(KIND_DIV,   0, 0,    1, 0, ST_DIV0,  0);
      add_row(KIND_PUSH,  -7, 0,   0, 0, ST_OK, 0);
      add_row(KIND_PUSH,  2, 0,    0, 0, ST_OK, 0);
      add_row(KIND_DIV,   0, 0,    1, -4, ST_OK, 1);
      add_row(KIND_PUSH,  minv, 0, 0, 0, ST_OK, 0);
      add_row(KIND_SUB,   0, 0,    0, 0, ST_OK, 0);
      add_row(KIND_PUSH,  3, 0,    0, 0, ST_OK, 0);
      add_row(KIND_PEEKB, 0, 1,    0, 0, ST_OK, 0);
      add_row(KIND_PEEKT, 0, 1023, 1, 0, ST_RANGE, 2);
      add_row(KIND_PEEKB, 0, 1023, 1, 0, ST_RANGE, 2);
      add_row(KIND_MUL,   0, 0,    0, 0, ST_OK, 0);
      add_row(KIND_POP,   0, 0,    0, 0, ST_OK, 0);

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i])
         send_beat(rows[i].kind, rows[i].value, rows[i].index, rows[i].typed, rows[i].answer);

      // fill to the top, overflow, then drain with peeks on the way
      for (int i = 0; i < DEPTH + 2; i++)
         send_beat(KIND_PUSH, $urandom, 0, 0, '0);
      send_beat(KIND_PEEKT, 0, 1023, 0, '0);
      send_beat(KIND_PEEKB, 0, 1023, 0, '0);
      send_beat(KIND_PEEKB, 0, 10'($urandom), 0, '0);
      while (calc_fill > 4)
         send_beat(kind_type'($urandom_range(1, 7)), 0, 10'($urandom), 0, '0);

      for (int i = 0; i < 500; i++) begin
         if (i == 420) quiet = 1'b1;
         n = $urandom_range(0, 9);
         if (calc_fill < 3 || n < 3) k = KIND_PUSH;
         else if (n < 5) k = kind_type'($urandom_range(1, 3));
         else k = kind_type'($urandom_range(4, 7));
         if (calc_fill > 40 && k == KIND_PUSH) k = KIND_ADD;
         if ($urandom_range(0, 19) == 0) k = kind_type'($urandom_range(0, 7));
         send_beat(k, rand_value(), 10'($urandom_range(0, 1) ? $urandom_range(0, calc_fill + 1)
                                                              : $urandom), 0, '0);
      end
      req_valid <= 1'b0;

      while (pending_answers.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0 && !timed_out) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule

// ===== files.f =====
hw/rtl/isc_pkg.sv
hw/rtl/isc_queue.sv
hw/rtl/isc_divider.sv
hw/rtl/isc_front.sv
hw/rtl/isc_exec.sv
hw/rtl/integer_stack_calculator_core.sv
sim/tb.sv
